// File: rtl/core/recsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and switch decoder package
// Shared types, event codes, register indexes and transition codes.
// ----------------------------------------------------------------------------
package recsd_pkg;

    // Width of the press counter.
    localparam int COUNT_BITS = 16;
    localparam int THR_BITS   = 16;
    // Common width for comparing the counter with the hold threshold.
    localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

    localparam logic [THR_BITS-1:0] HOLD_THR_RESET = THR_BITS'(100);

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_HOLD    = 3'd2,
        EV_RELEASE = 3'd3,
        EV_UP      = 3'd4,
        EV_DOWN    = 3'd5
    } t_event;

    // Configuration register indexes.
    localparam logic CFG_FAST_STEP      = 1'b0;
    localparam logic CFG_HOLD_THRESHOLD = 1'b1;

    // Transition words, new phase in the upper pair and last phase in the lower.
    localparam logic [3:0] TR_UP_32   = 4'b10_11;
    localparam logic [3:0] TR_UP_20   = 4'b00_10;
    localparam logic [3:0] TR_UP_01   = 4'b01_00;
    localparam logic [3:0] TR_UP_13   = 4'b11_01;
    localparam logic [3:0] TR_DOWN_23 = 4'b11_10;
    localparam logic [3:0] TR_DOWN_31 = 4'b01_11;
    localparam logic [3:0] TR_DOWN_02 = 4'b10_00;
    localparam logic [3:0] TR_DOWN_10 = 4'b00_01;

    typedef struct packed {
        logic                fast_step;
        logic [THR_BITS-1:0] hold_threshold;
    } t_cfg;

endpackage

// File: rtl/core/recsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan request channel
// Carries one scan sample: the two phase levels and the switch level.
// ----------------------------------------------------------------------------
interface recsd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] quad_bits;
    logic       switch_pressed;

    modport source (output valid, output quad_bits, output switch_pressed, input ready);
    modport sink   (input valid, input quad_bits, input switch_pressed, output ready);
endinterface

// File: rtl/core/recsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event result channel
// Carries one event code per scan.
// ----------------------------------------------------------------------------
interface recsd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

// File: rtl/core/recsd_switch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push switch tracker
// Keeps the switch memory, press counter and release mask, and reports
// press, hold and release events.
// ----------------------------------------------------------------------------
module recsd_switch
    import recsd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  logic   i_pressed,
    input  t_cfg   i_cfg,
    output t_event o_event
);

    logic                  r_mem;
    logic                  r_mask;
    logic [COUNT_BITS-1:0] r_count;
    logic                  n_mem;
    logic                  n_mask;
    logic [COUNT_BITS-1:0] n_count;

    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] inc;
    logic [CMP_BITS-1:0]   thr_x;

    assign thr_x = CMP_BITS'(i_cfg.hold_threshold);

    always_comb begin
        n_mem   = r_mem;
        n_mask  = r_mask;
        n_count = r_count;
        o_event = EV_NONE;
        // A fresh press restarts the count from zero.
        base    = r_mem ? r_count : '0;
        inc     = base + COUNT_BITS'(1);
        if (i_pressed) begin
            n_mem   = 1'b1;
            n_count = base;
            if (!r_mem) begin
                o_event = EV_PRESS;
            end
            if ((CMP_BITS'(base) < thr_x) && !(&base)) begin
                n_count = inc;
                if (CMP_BITS'(inc) == thr_x) begin
                    o_event = EV_HOLD;
                    n_mask  = 1'b1;
                end
            end
        end else if (r_mem) begin
            n_mem = 1'b0;
            if (r_mask) begin
                n_mask = 1'b0;
            end else if (CMP_BITS'(r_count) < thr_x) begin
                o_event = EV_RELEASE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem   <= 1'b0;
            r_mask  <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            r_mem   <= n_mem;
            r_mask  <= n_mask;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/recsd_turn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature phase decoder
// Holds the last phase pair and decodes a change into an up or down step.
// ----------------------------------------------------------------------------
module recsd_turn
    import recsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_phase,
    input  logic       i_fast_step,
    output t_event     o_event
);

    logic [1:0] r_last;
    logic [3:0] word;

    assign word = {i_phase, r_last};

    always_comb begin
        o_event = EV_NONE;
        if (i_fast_step) begin
            case (word)
                TR_UP_32, TR_UP_20, TR_UP_01, TR_UP_13:         o_event = EV_UP;
                TR_DOWN_23, TR_DOWN_31, TR_DOWN_02, TR_DOWN_10: o_event = EV_DOWN;
                default:                                        o_event = EV_NONE;
            endcase
        end else begin
            case (word)
                TR_UP_32:   o_event = EV_UP;
                TR_DOWN_23: o_event = EV_DOWN;
                default:    o_event = EV_NONE;
            endcase
        end
    end

    // Unchanged phases decode to no step, so the pair is simply stored each scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 2'b00;
        end else if (i_step) begin
            r_last <= i_phase;
        end
    end

endmodule

// File: rtl/core/rotary_encoder_switch_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and switch decoder core
// Turns scan samples of a quadrature encoder with push switch into events.
// ----------------------------------------------------------------------------
// Usage:
// Each request on i_req carries one scan: the two phase levels and the
// switch level. For every request exactly one event code leaves on o_evt:
// none, press, hold, release, up or down. A step event replaces a switch
// event of the same scan.
// A request is registered on acceptance in the input register, and its event
// is computed from there into the output register when that register is
// empty or its event is being taken. One request is taken every cycle while
// the receiver takes events; the input register and the output register form
// a two-entry pipeline, so the block keeps taking requests while a finished
// event still waits.
// When o_evt stalls, the event is held, one more request is absorbed in the
// input register, then i_req.ready drops until the receiver takes the event.
// Reset empties both registers, clears the phase and switch state, and sets
// fast_step to 0 and hold_threshold to 100. The user must write registers
// through i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module rotary_encoder_switch_decoder_core
    import recsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    recsd_in_if.sink            i_req,
    recsd_out_if.source         o_evt,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [THR_BITS-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_s1_valid;
    logic [1:0] r_s1_quad;
    logic       r_s1_pressed;
    logic       r_out_valid;
    t_event     r_out_event;

    logic   out_load;
    logic   s1_adv;
    logic   in_ready;
    t_event sw_event;
    t_event turn_event;
    t_event n_event;

    assign out_load = !r_out_valid || o_evt.ready;
    assign s1_adv   = r_s1_valid && out_load;
    assign in_ready = !r_s1_valid || out_load;

    assign i_req.ready      = in_ready;
    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_code = r_out_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_step      <= 1'b0;
            r_cfg.hold_threshold <= HOLD_THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FAST_STEP:      r_cfg.fast_step      <= i_cfg_data[0];
                CFG_HOLD_THRESHOLD: r_cfg.hold_threshold <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.valid && in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_s1_quad    <= i_req.quad_bits;
            r_s1_pressed <= i_req.switch_pressed;
        end
    end

    recsd_switch u_switch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s1_adv),
        .i_pressed (r_s1_pressed),
        .i_cfg     (r_cfg),
        .o_event   (sw_event)
    );

    recsd_turn u_turn (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_adv),
        .i_phase     (r_s1_quad),
        .i_fast_step (r_cfg.fast_step),
        .o_event     (turn_event)
    );

    assign n_event = (turn_event != EV_NONE) ? turn_event : sw_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_event <= n_event;
        end
    end

    // Back pressure on the request side only when the input register is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_out_valid && !o_evt.ready))
        else $error("request side stalled without a full pipeline");

    // A waiting event is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_evt.ready) |-> !s1_adv)
        else $error("pending event overwritten");

    // A new event appears only after a scan left the input register.
    a_rose_from_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv))
        else $error("event appeared without a scan");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary encoder and switch decoder testbench
// Sends scan requests in bursts against an event receiver that stalls, takes
// each expected event code from the directed table or from a behavioral copy
// of the decoder, and checks the events in order. A short table of directed
// scans comes first. Random encoder motion and switch presses follow under several
// register settings, including one press held past a hold threshold of two hundred scans.
// ----------------------------------------------------------------------------
module tb_top;
    import recsd_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_stall_mode;

    typedef struct {
        bit                  is_cfg;
        logic                cfg_idx;
        logic [THR_BITS-1:0] cfg_val;
        logic [1:0]          quad;
        logic                sw;
        bit                  known;
        t_event              evt;
    } t_row;

    typedef struct {
        logic                fast;
        logic [THR_BITS-1:0] thr;
        int                  scans;
        int                  move_pct;
        bit                  long_press;
    } t_setting;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [THR_BITS-1:0] i_cfg_data;

    recsd_in_if  req_if();
    recsd_out_if evt_if();

    rotary_encoder_switch_decoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_evt       (evt_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Behavioral copy of the decoder state and its registers.
    logic                  cfg_fast;
    logic [THR_BITS-1:0]   cfg_thr;
    logic [1:0]            enc_phase;
    logic                  sw_down;
    logic [COUNT_BITS-1:0] press_cnt;
    logic                  hold_seen;

    t_event pending_events[$];
    int     err_count   = 0;
    int     idle_cycles = 0;

    // A typed expectation travels with the request that carries it.
    bit     row_known = 1'b0;
    t_event row_evt   = EV_NONE;

    int     burst_left = 0;

    // Random encoder walk and switch run state.
    logic [1:0] walk_phase = 2'd0;
    bit         walk_up    = 1'b1;
    logic       sw_level   = 1'b0;
    int         run_left   = 0;
    int         move_pct   = 50;

    t_stall_mode rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [4:0]  rx_tick = '0;

    t_row     dir_rows[$];
    t_setting settings[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_event decode_scan(logic [1:0] quad, logic sw);
        t_event     evt;
        logic [3:0] word;
        evt  = EV_NONE;
        word = {quad, enc_phase};
        if (sw) begin
            if (!sw_down) begin
                sw_down   = 1'b1;
                evt       = EV_PRESS;
                press_cnt = '0;
            end
            if (press_cnt < cfg_thr && press_cnt != '1) begin
                press_cnt = press_cnt + 1'b1;
                if (press_cnt == cfg_thr) begin
                    evt       = EV_HOLD;
                    hold_seen = 1'b1;
                end
            end
        end else if (sw_down) begin
            sw_down = 1'b0;
            if (hold_seen) begin
                hold_seen = 1'b0;
            end else if (press_cnt < cfg_thr) begin
                evt = EV_RELEASE;
            end
        end
        if (quad != enc_phase) begin
            if (cfg_fast) begin
                case (word)
                    TR_UP_32, TR_UP_20, TR_UP_01, TR_UP_13: evt = EV_UP;
                    TR_DOWN_23, TR_DOWN_31, TR_DOWN_02, TR_DOWN_10: evt = EV_DOWN;
                    default: ;
                endcase
            end else if (word == TR_UP_32) begin
                evt = EV_UP;
            end else if (word == TR_DOWN_23) begin
                evt = EV_DOWN;
            end
            enc_phase = quad;
        end
        return evt;
    endfunction

    // One quadrature step from a phase; up runs 0, 1, 3, 2.
    function automatic logic [1:0] turn_phase(logic [1:0] p, bit up);
        case (p)
            2'd0:    return up ? 2'd1 : 2'd2;
            2'd1:    return up ? 2'd3 : 2'd0;
            2'd2:    return up ? 2'd0 : 2'd3;
            default: return up ? 2'd2 : 2'd1;
        endcase
    endfunction

    function automatic t_row known_row(logic [1:0] quad, logic sw, t_event evt);
        t_row r;
        r = '{1'b0, CFG_FAST_STEP, '0, quad, sw, 1'b1, evt};
        return r;
    endfunction

    function automatic t_row open_row(logic [1:0] quad, logic sw);
        t_row r;
        r = '{1'b0, CFG_FAST_STEP, '0, quad, sw, 1'b0, EV_NONE};
        return r;
    endfunction

    function automatic t_row cfg_row(logic idx, logic [THR_BITS-1:0] val);
        t_row r;
        r = '{1'b1, idx, val, 2'd0, 1'b0, 1'b0, EV_NONE};
        return r;
    endfunction

    // Request side and result side share one block so that a request and a
    // result accepted at the same edge are handled in a fixed order.
    always @(posedge i_clk) begin
        t_event want;
        t_event got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                want = decode_scan(req_if.quad_bits, req_if.switch_pressed);
                pending_events.push_back(row_known ? row_evt : want);
            end
            if (evt_if.valid && evt_if.ready) begin
                got = t_event'(evt_if.event_code);
                if (pending_events.size() == 0) begin
                    $error("event_code: no result expected, actual %0d", evt_if.event_code);
                    err_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (evt_if.event_code !== want) begin
                        $error("event_code: expected %0d, actual %0d", want, got);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (req_if.valid && req_if.ready)
                || (evt_if.valid && evt_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver switches at random between stall patterns: open, light, heavy and periodic.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_left == 0) begin
            rx_mode <= t_stall_mode'($urandom_range(3));
            rx_left <= $urandom_range(400, 50);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  evt_if.ready <= 1'b1;
            RX_LIGHT: evt_if.ready <= ($urandom_range(99) < 80);
            RX_HEAVY: evt_if.ready <= ($urandom_range(99) < 35);
            default:  evt_if.ready <= (rx_tick < 5'd20);
        endcase
    end

    task automatic send_scan(input logic [1:0] quad, input logic sw, input bit known,
                             input t_event evt);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60)
                                                  : $urandom_range(30, 1);
            gap = $urandom_range(8, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        req_if.valid          <= 1'b1;
        req_if.quad_bits      <= quad;
        req_if.switch_pressed <= sw;
        row_known             <= known;
        row_evt               <= evt;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stops sending and waits until every expected event has been taken.
    task automatic drain_events();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [THR_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FAST_STEP) begin
            cfg_fast = val[0];
        end else begin
            cfg_thr = val;
        end
        @(posedge i_clk);
    endtask

    task automatic random_scan(output logic [1:0] quad, output logic sw);
        int r;
        int len;
        r = $urandom_range(99);
        if (r < move_pct) begin
            walk_phase = turn_phase(walk_phase, walk_up);
        end else if (r < move_pct + 5) begin
            walk_phase = turn_phase(walk_phase, !walk_up);
        end else if (r >= 95) begin
            // Noise: any level, double jumps included.
            walk_phase = 2'($urandom);
        end
        if ($urandom_range(49) == 0) walk_up = !walk_up;
        if (run_left == 0) begin
            sw_level = !sw_level;
            if (sw_level) begin
                r = $urandom_range(9);
                if (r < 3) begin
                    // Presses that end just short of, at, or just past the hold.
                    len = int'(cfg_thr) + int'($urandom_range(2)) - 1;
                    if (len > 400) len = $urandom_range(300, 1);
                end else if (r < 7) begin
                    len = $urandom_range(6, 1);
                end else begin
                    len = $urandom_range(300, 1);
                end
                run_left = (len < 1) ? 1 : len;
            end else begin
                run_left = $urandom_range(12, 1);
            end
        end
        run_left--;
        quad = walk_phase;
        sw   = sw_level;
    endtask

    initial begin
        logic [1:0] q;
        logic       s;

        cfg_fast  = 1'b0;
        cfg_thr   = HOLD_THR_RESET;
        enc_phase = 2'd0;
        sw_down   = 1'b0;
        press_cnt = '0;
        hold_seen = 1'b0;

        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_index           <= CFG_FAST_STEP;
        i_cfg_data            <= '0;
        req_if.valid          <= 1'b0;
        req_if.quad_bits      <= 2'd0;
        req_if.switch_pressed <= 1'b0;

        // Slow mode after reset: only the 3-2 and 2-3 transitions step.
        dir_rows.push_back(known_row(2'd0, 1'b0, EV_NONE));
        dir_rows.push_back(known_row(2'd3, 1'b0, EV_NONE));
        dir_rows.push_back(known_row(2'd2, 1'b0, EV_UP));
        dir_rows.push_back(known_row(2'd3, 1'b0, EV_DOWN));
        dir_rows.push_back(known_row(2'd1, 1'b0, EV_NONE));
        dir_rows.push_back(known_row(2'd1, 1'b1, EV_PRESS));
        dir_rows.push_back(known_row(2'd1, 1'b1, EV_NONE));
        dir_rows.push_back(known_row(2'd1, 1'b0, EV_RELEASE));
        dir_rows.push_back(open_row(2'd0, 1'b1));
        dir_rows.push_back(open_row(2'd2, 1'b0));
        // A step replaces the switch event of the same scan.
        dir_rows.push_back(open_row(2'd3, 1'b1));
        dir_rows.push_back(open_row(2'd2, 1'b0));
        dir_rows.push_back(cfg_row(CFG_FAST_STEP, THR_BITS'(1)));
        dir_rows.push_back(cfg_row(CFG_HOLD_THRESHOLD, THR_BITS'(2)));
        dir_rows.push_back(known_row(2'd0, 1'b1, EV_UP));
        dir_rows.push_back(known_row(2'd0, 1'b1, EV_HOLD));
        dir_rows.push_back(known_row(2'd0, 1'b1, EV_NONE));
        // The release after a hold is masked.
        dir_rows.push_back(known_row(2'd0, 1'b0, EV_NONE));
        dir_rows.push_back(known_row(2'd1, 1'b0, EV_UP));
        dir_rows.push_back(known_row(2'd3, 1'b0, EV_UP));
        dir_rows.push_back(known_row(2'd2, 1'b0, EV_UP));
        dir_rows.push_back(known_row(2'd0, 1'b0, EV_UP));
        dir_rows.push_back(known_row(2'd2, 1'b0, EV_DOWN));
        dir_rows.push_back(known_row(2'd3, 1'b0, EV_DOWN));
        dir_rows.push_back(known_row(2'd1, 1'b0, EV_DOWN));
        dir_rows.push_back(known_row(2'd0, 1'b0, EV_DOWN));
        dir_rows.push_back(open_row(2'd3, 1'b0));

        settings.push_back('{1'b0, THR_BITS'(1),     200, 60, 1'b0});
        settings.push_back('{1'b1, THR_BITS'(0),     200, 50, 1'b0});
        settings.push_back('{1'b1, THR_BITS'(3),     150, 30, 1'b0});
        settings.push_back('{1'b0, THR_BITS'(100),   150, 40, 1'b0});
        settings.push_back('{1'b1, THR_BITS'(65535), 250, 70, 1'b0});
        settings.push_back('{1'b0, THR_BITS'(2),     200, 20, 1'b0});
        settings.push_back('{1'b1, THR_BITS'(17),    200, 25, 1'b0});
        settings.push_back('{1'b0, THR_BITS'(5),     150, 80, 1'b0});
        // One press held past a long threshold, with little motion so that
        // the hold is not hidden behind a step.
        settings.push_back('{1'b0, THR_BITS'(200),   210, 2, 1'b1});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_events();
                write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
            end else begin
                send_scan(dir_rows[k].quad, dir_rows[k].sw, dir_rows[k].known,
                          dir_rows[k].evt);
            end
        end

        walk_phase = enc_phase;
        foreach (settings[k]) begin
            drain_events();
            write_reg(CFG_FAST_STEP, THR_BITS'(settings[k].fast));
            write_reg(CFG_HOLD_THRESHOLD, settings[k].thr);
            move_pct = settings[k].move_pct;
            if (settings[k].long_press) begin
                sw_level = 1'b1;
                run_left = int'(settings[k].thr) + 3;
            end
            repeat (settings[k].scans) begin
                random_scan(q, s);
                send_scan(q, s, 1'b0, EV_NONE);
            end
        end

        drain_events();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: rotary_encoder_switch_decoder_core.f
rtl/core/recsd_pkg.sv
rtl/core/recsd_in_if.sv
rtl/core/recsd_out_if.sv
rtl/core/recsd_switch.sv
rtl/core/recsd_turn.sv
rtl/core/rotary_encoder_switch_decoder_core.sv
tb/tb_top.sv
